// ===== rtl/core/dts_pkg.sv =====
package dts_pkg;

    localparam int MAX_DELIM_DEF = 8;
    localparam int PATTERN_BYTES = 8;
    localparam int LEN_W         = 4;
    localparam int PATTERN_W     = 64;

    localparam logic [0:0] CFG_DELIM_LENGTH  = 1'b0;
    localparam logic [0:0] CFG_DELIM_PATTERN = 1'b1;

    localparam logic [LEN_W-1:0]     LEN_RESET     = 4'd1;
    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 64'h0000_0000_0000_0020;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] TAB_BYTE   = 8'h09;
    localparam logic [7:0] CR_BYTE    = 8'h0d;

    typedef struct packed {
        logic [7:0] tok_byte;
        logic       byte_valid;
        logic       tok_end;
        logic       done;
    } res_t;

    typedef struct packed {
        logic emit;
        logic finish;
        res_t res;
    } req_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
    endfunction

endpackage

// ===== rtl/core/delimiter_token_splitter.sv =====
// Streaming string splitter. One source byte per input beat (byte_present), src_end closes
// the string; tokens come out one byte per output beat, each token closed by a beat with
// tok_end, the final beat of a string carrying split_done, and run_last marking the last
// beat caused by an input beat. A row of byte cells holds the partial delimiter match and
// handles one byte per cycle while the output stage is not full and stalled. An input beat
// is accepted, bytes are released from or passed through the row one at a time, the row is
// found matching or empty, and a finish step follows; when src_end is set, draining the
// held bytes, a second empty check and the closing beat come before the finish. Every
// step after acceptance waits while the output stage is full and stalled; the output
// stage holds one beat back so that run_last is known before it is shown. Write
// delim_length and delim_pattern only while the block is idle; a single space delimiter
// selects whitespace splitting.
module delimiter_token_splitter #(
    parameter int MAX_DELIM = dts_pkg::MAX_DELIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  src_byte,
    input  logic        byte_present,
    input  logic        src_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tok_byte,
    output logic        tok_byte_valid,
    output logic        tok_end,
    output logic        split_done,
    output logic        run_last
);

    localparam int NCELL = (MAX_DELIM < dts_pkg::PATTERN_BYTES) ? MAX_DELIM
                                                                 : dts_pkg::PATTERN_BYTES;
    localparam int CNT_W = $clog2(NCELL + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WS     = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [dts_pkg::LEN_W-1:0]     len_reg;
    logic [dts_pkg::LEN_W-1:0]     len_next;
    logic [dts_pkg::PATTERN_W-1:0] pattern_reg;
    logic [dts_pkg::PATTERN_W-1:0] pattern_next;
    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          tok_ne_reg;
    logic                          tok_ne_next;
    logic                          end_reg;
    logic                          end_next;

    logic [dts_pkg::LEN_W-1:0] eff_len;
    logic [dts_pkg::LEN_W-1:0] cnt_ext;
    logic                      ws_mode;
    logic                      window_match;
    logic                      load_en;
    logic                      shift;
    logic                      adv;
    dts_pkg::req_t             req;

    logic [7:0]       cell_byte [NCELL];
    logic [NCELL-1:0] cell_eq;
    logic [NCELL-1:0] prefix_ok;

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = dts_pkg::LEN_W'(1);
        end
        else if (len_reg > dts_pkg::LEN_W'(NCELL))
        begin
            eff_len = dts_pkg::LEN_W'(NCELL);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    assign ws_mode      = (eff_len == dts_pkg::LEN_W'(1))
                          && (pattern_reg[7:0] == dts_pkg::SPACE_BYTE);
    assign cnt_ext      = dts_pkg::LEN_W'(cnt_reg);
    assign window_match = (&prefix_ok) && (cnt_ext <= eff_len);

    // byte cells: cell 0 is the oldest held byte, shifting moves every byte one cell down
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        logic [7:0] din_next;
        logic       load_g;

        if (g == NCELL - 1)
        begin : g_tail
            assign din_next = 8'h00;
        end
        else
        begin : g_link
            assign din_next = cell_byte[g+1];
        end

        assign load_g       = load_en && (cnt_reg == CNT_W'(g));
        assign prefix_ok[g] = (cnt_reg <= CNT_W'(g)) || cell_eq[g];

        dts_cell u_cell (
            .clk        (clk),
            .load       (load_g),
            .shift      (shift),
            .din_new    (src_byte),
            .din_next   (din_next),
            .delim_byte (pattern_reg[8*g +: 8]),
            .byte_q     (cell_byte[g]),
            .eq         (cell_eq[g])
        );
    end

    always_comb
    begin
        len_next     = len_reg;
        pattern_next = pattern_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dts_pkg::CFG_DELIM_LENGTH:  len_next     = cfg_data[dts_pkg::LEN_W-1:0];
                dts_pkg::CFG_DELIM_PATTERN: pattern_next = cfg_data;
                default:                    len_next     = len_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        tok_ne_next = tok_ne_reg;
        end_next    = end_reg;
        load_en     = 1'b0;
        shift       = 1'b0;
        req         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    load_en  = byte_present;
                    end_next = src_end;
                    if (byte_present)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (ws_mode)
                    begin
                        state_next = (byte_present || src_end) ? S_WS : S_FINISH;
                    end
                    else if (byte_present)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = src_end ? S_DRAIN : S_FINISH;
                    end
                end
            end
            S_WS:
            begin
                if (adv)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = end_reg ? S_FINAL : S_FINISH;
                    end
                    else
                    begin
                        shift    = 1'b1;
                        cnt_next = cnt_reg - CNT_W'(1);
                        if (dts_pkg::is_space(cell_byte[0]))
                        begin
                            if (tok_ne_reg)
                            begin
                                req.emit        = 1'b1;
                                req.res.tok_end = 1'b1;
                                tok_ne_next     = 1'b0;
                            end
                        end
                        else
                        begin
                            req.emit           = 1'b1;
                            req.res.tok_byte   = cell_byte[0];
                            req.res.byte_valid = 1'b1;
                            tok_ne_next        = 1'b1;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (adv)
                begin
                    if (window_match)
                    begin
                        if (cnt_ext == eff_len)
                        begin
                            req.emit        = 1'b1;
                            req.res.tok_end = 1'b1;
                            tok_ne_next     = 1'b0;
                            cnt_next        = '0;
                        end
                        state_next = end_reg ? S_DRAIN : S_FINISH;
                    end
                    else
                    begin
                        req.emit           = 1'b1;
                        req.res.tok_byte   = cell_byte[0];
                        req.res.byte_valid = 1'b1;
                        tok_ne_next        = 1'b1;
                        shift              = 1'b1;
                        cnt_next           = cnt_reg - CNT_W'(1);
                    end
                end
            end
            S_DRAIN:
            begin
                if (adv)
                begin
                    if (cnt_reg != '0)
                    begin
                        req.emit           = 1'b1;
                        req.res.tok_byte   = cell_byte[0];
                        req.res.byte_valid = 1'b1;
                        tok_ne_next        = 1'b1;
                        shift              = 1'b1;
                        cnt_next           = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_FINAL:
            begin
                if (adv)
                begin
                    req.emit        = 1'b1;
                    req.res.tok_end = tok_ne_reg;
                    req.res.done    = 1'b1;
                    tok_ne_next     = 1'b0;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                req.finish = 1'b1;
                if (adv)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= dts_pkg::LEN_RESET;
            pattern_reg <= dts_pkg::PATTERN_RESET;
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            tok_ne_reg  <= 1'b0;
            end_reg     <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            pattern_reg <= pattern_next;
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tok_ne_reg  <= tok_ne_next;
            end_reg     <= end_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    dts_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .adv            (adv),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tok_byte       (tok_byte),
        .tok_byte_valid (tok_byte_valid),
        .tok_end        (tok_end),
        .split_done     (split_done),
        .run_last       (run_last)
    );

endmodule

// ===== rtl/core/dts_cell.sv =====
module dts_cell (
    input  logic       clk,
    input  logic       load,
    input  logic       shift,
    input  logic [7:0] din_new,
    input  logic [7:0] din_next,
    input  logic [7:0] delim_byte,
    output logic [7:0] byte_q,
    output logic       eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (load)
        begin
            byte_next = din_new;
        end
        else if (shift)
        begin
            byte_next = din_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;
    assign eq     = (byte_reg == delim_byte);

endmodule

// ===== rtl/core/dts_out.sv =====
module dts_out (
    input  logic              clk,
    input  logic              rst_n,
    input  dts_pkg::req_t     req,
    output logic              adv,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        tok_byte,
    output logic              tok_byte_valid,
    output logic              tok_end,
    output logic              split_done,
    output logic              run_last
);

    dts_pkg::res_t hold_reg;
    dts_pkg::res_t hold_next;
    logic          hold_valid_reg;
    logic          hold_valid_next;
    dts_pkg::res_t out_res_reg;
    dts_pkg::res_t out_res_next;
    logic          out_last_reg;
    logic          out_last_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_free;
    logic          emit_fire;
    logic          fin_fire;
    logic          push;

    assign out_free  = !out_valid_reg || !out_stall;
    assign adv       = !hold_valid_reg || out_free;
    assign emit_fire = req.emit && adv;
    assign fin_fire  = req.finish && adv;
    assign push      = hold_valid_reg && (emit_fire || fin_fire);

    // the held result goes out marked last only when the item finishes
    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (push)
        begin
            out_res_next   = hold_reg;
            out_last_next  = fin_fire;
            out_valid_next = 1'b1;
        end
        if (emit_fire)
        begin
            hold_next       = req.res;
            hold_valid_next = 1'b1;
        end
        else if (fin_fire)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign tok_byte       = out_res_reg.tok_byte;
    assign tok_byte_valid = out_res_reg.byte_valid;
    assign tok_end        = out_res_reg.tok_end;
    assign split_done     = out_res_reg.done;
    assign run_last       = out_last_reg;

endmodule

// ===== rtl/core/dts_checker.sv =====
module dts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] tok_byte,
    input logic       tok_byte_valid,
    input logic       tok_end,
    input logic       split_done,
    input logic       run_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tok_byte) && $stable(tok_byte_valid)
            && $stable(tok_end) && $stable(split_done) && $stable(run_last))
        else $error("stalled output beat changed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && split_done |-> run_last && !tok_byte_valid)
        else $error("split_done beat not last or carries a byte");

    a_byte_or_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tok_byte_valid && tok_end))
        else $error("beat carries both a byte and a token end");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tok_byte_valid |-> tok_byte == 8'h00)
        else $error("tok_byte not zero without a byte");

    // more beats of the same input beat still to come, so no new input is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> in_stall)
        else $error("input taken while results of an earlier beat are pending");

endmodule

bind delimiter_token_splitter dts_checker u_dts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tok_byte       (tok_byte),
    .tok_byte_valid (tok_byte_valid),
    .tok_end        (tok_end),
    .split_done     (split_done),
    .run_last       (run_last)
);
